[rtl/core/lcd4_pkg.sv]
// Shared types, constants and the power-up strobe table for the 4-bit
// character display sequencer. No dependencies.
package lcd4_pkg;

   // Request function codes
   localparam logic [2:0] FUNC_COMMAND  = 3'd0;
   localparam logic [2:0] FUNC_DATA     = 3'd1;
   localparam logic [2:0] FUNC_GOTO     = 3'd2;
   localparam logic [2:0] FUNC_HOME     = 3'd3;
   localparam logic [2:0] FUNC_CLRLINE  = 3'd4;
   localparam logic [2:0] FUNC_INIT     = 3'd5;

   // Configuration register indexes
   localparam logic CSR_LINE_LENGTH     = 1'b0;
   localparam logic CSR_SECOND_ROW_BASE = 1'b1;

   localparam int CSR_DATA_W = 7;

   // Reset values of the configuration registers
   localparam logic [4:0] LINE_LENGTH_RST     = 5'd16;
   localparam logic [6:0] SECOND_ROW_BASE_RST = 7'h40;
   localparam logic [4:0] MAX_COLS            = 5'd16;

   // Display opcodes and characters
   localparam logic [7:0] OP_CLEAR     = 8'h01;
   localparam logic [7:0] OP_HOME      = 8'h02;
   localparam logic       OP_DDRAM_BIT = 1'b1;
   localparam logic [3:0] SPACE_HI     = 4'h2;
   localparam logic [3:0] SPACE_LO     = 4'h0;

   // Timing in microseconds
   localparam logic [12:0] SETTLE_BASE  = 13'd40;
   localparam logic [12:0] SETTLE_CLEAR = 13'd2040;
   localparam logic [12:0] SETTLE_HOME  = 13'd4040;
   localparam logic [12:0] SETTLE_WAKE  = 13'd5040;
   localparam logic [12:0] SETTLE_SYNC  = 13'd190;
   localparam logic [15:0] POWER_WAIT   = 16'd50000;

   // Job queue depth between front and back
   localparam int JOBQ_DEPTH = 2;

   // Strobe counter: longest request is 36 strobes
   localparam int STEP_W = 6;

   typedef enum logic [1:0] {
      JOB_BYTE    = 2'd0,
      JOB_CLRLINE = 2'd1,
      JOB_INIT    = 2'd2
   } job_kind_type;

   // Classified request handed from front to back
   typedef struct packed {
      job_kind_type kind;
      logic         rs;
      logic [7:0]   value;
      logic [12:0]  settle_lo;
      logic         row;
   } job_type;

   typedef struct packed {
      logic        register_select;
      logic [3:0]  nibble;
      logic [15:0] wait_before_us;
      logic [12:0] settle_us;
      logic        last;
   } strobe_type;

   // Power-up sequence: three wake nibbles, switch to 4-bit, then
   // function set, display off, clear, entry mode, display on.
   function automatic strobe_type init_strobe(input logic [3:0] idx);
      strobe_type s;
      s.register_select = 1'b0;
      s.wait_before_us  = 16'd0;
      s.settle_us       = SETTLE_BASE;
      s.last            = 1'b0;
      s.nibble          = 4'h0;
      case (idx)
         4'd0: begin
            s.nibble = 4'h3; s.wait_before_us = POWER_WAIT; s.settle_us = SETTLE_WAKE;
         end
         4'd1: begin s.nibble = 4'h3; s.settle_us = SETTLE_SYNC; end
         4'd2: begin s.nibble = 4'h3; s.settle_us = SETTLE_SYNC; end
         4'd3: begin s.nibble = 4'h2; s.settle_us = SETTLE_SYNC; end
         4'd4: s.nibble = 4'h2;
         4'd5: s.nibble = 4'h8;
         4'd6: s.nibble = 4'h0;
         4'd7: s.nibble = 4'h8;
         4'd8: s.nibble = 4'h0;
         4'd9: begin s.nibble = 4'h1; s.settle_us = SETTLE_CLEAR; end
         4'd10: s.nibble = 4'h0;
         4'd11: s.nibble = 4'h6;
         4'd12: s.nibble = 4'h0;
         4'd13: begin s.nibble = 4'hC; s.last = 1'b1; end
         default: s.nibble = 4'h0;
      endcase
      return s;
   endfunction

endpackage

[rtl/core/lcd4_front.sv]
// Request classifier: turns a request into a job for the strobe sequencer.
// Depends on lcd4_pkg.
module lcd4_front
   import lcd4_pkg::*;
(
   input  logic [2:0] func,
   input  logic [7:0] byte_value,
   input  logic [3:0] column,
   input  logic       row,
   input  logic [6:0] second_row_base,
   output logic       job_valid,
   output job_type    job
);

   logic [6:0] goto_addr;

   // Display address of the goto target, wrapping in 7 bits
   assign goto_addr = (row ? second_row_base : 7'd0) + {3'd0, column};

   // Classify the request; unused codes make no job
   always_comb begin
      job_valid     = 1'b1;
      job.kind      = JOB_BYTE;
      job.rs        = 1'b0;
      job.value     = byte_value;
      job.settle_lo = SETTLE_BASE;
      job.row       = row;
      case (func)
         FUNC_COMMAND: begin
            if (byte_value == OP_CLEAR || byte_value == OP_HOME) job.settle_lo = SETTLE_CLEAR;
         end
         FUNC_DATA: job.rs = 1'b1;
         FUNC_GOTO: job.value = {OP_DDRAM_BIT, goto_addr};
         FUNC_HOME: begin
            job.value     = OP_HOME;
            job.settle_lo = SETTLE_HOME;
         end
         FUNC_CLRLINE: job.kind = JOB_CLRLINE;
         FUNC_INIT: job.kind = JOB_INIT;
         default: job_valid = 1'b0;
      endcase
   end

endmodule

[rtl/core/lcd4_jobq.sv]
// Short job queue between the classifier and the strobe sequencer.
// Depends on lcd4_pkg.
module lcd4_jobq
   import lcd4_pkg::*;
#(
   parameter int DEPTH = JOBQ_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_en,
   input  job_type wr_job,
   input  logic    rd_en,
   output job_type rd_job,
   output logic    full,
   output logic    empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   job_type          slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr, do_rd;

   assign full   = (count_ff == CNT_FULL);
   assign empty  = (count_ff == '0);
   assign do_wr  = wr_en && !full;
   assign do_rd  = rd_en && !empty;
   assign rd_job = slot_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      if (do_rd) rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      if (do_wr && !do_rd) count_in = count_ff + 1'b1;
      else if (do_rd && !do_wr) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the job
   always_ff @(posedge clock) begin
      if (do_wr) slot_ff[wr_ptr_ff] <= wr_job;
   end

endmodule

[rtl/core/lcd4_back.sv]
// Strobe sequencer: steps through one job a strobe per cycle into an output
// register while that register has room. Depends on lcd4_pkg.
module lcd4_back
   import lcd4_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       job_avail,
   input  job_type    job,
   output logic       job_pop,
   input  logic [4:0] line_length,
   input  logic [6:0] second_row_base,
   output logic       out_valid,
   output strobe_type out_strobe,
   input  logic       out_pop
);

   logic              active_ff, active_in;
   job_type           job_ff;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              out_valid_ff, out_valid_in;
   strobe_type        out_strobe_ff;
   strobe_type        cur;
   logic              out_room, emit;
   logic [4:0]        n_cols;
   logic [STEP_W-1:0] space_end, final_step;
   logic [7:0]        line_addr;

   assign out_room  = !out_valid_ff || out_pop;
   assign emit      = active_ff && out_room;
   assign job_pop   = !active_ff && job_avail;
   assign out_valid = out_valid_ff;
   assign out_strobe = out_strobe_ff;

   // Clear-line geometry: goto, n spaces, goto
   assign n_cols     = (line_length > MAX_COLS) ? MAX_COLS : line_length;
   assign space_end  = {n_cols, 1'b0} + STEP_W'(2);
   assign final_step = {n_cols, 1'b0} + STEP_W'(3);
   assign line_addr  = {OP_DDRAM_BIT, (job_ff.row ? second_row_base : 7'd0)};

   // Build the strobe for the current step
   always_comb begin
      cur.register_select = job_ff.rs;
      cur.wait_before_us  = 16'd0;
      cur.settle_us       = SETTLE_BASE;
      cur.nibble          = step_ff[0] ? job_ff.value[3:0] : job_ff.value[7:4];
      cur.last            = step_ff[0];
      case (job_ff.kind)
         JOB_BYTE: begin
            if (step_ff[0]) cur.settle_us = job_ff.settle_lo;
         end
         JOB_CLRLINE: begin
            cur.last = (step_ff == final_step);
            if (step_ff >= STEP_W'(2) && step_ff < space_end) begin
               cur.register_select = 1'b1;
               cur.nibble          = step_ff[0] ? SPACE_LO : SPACE_HI;
            end else begin
               cur.register_select = 1'b0;
               cur.nibble          = step_ff[0] ? line_addr[3:0] : line_addr[7:4];
            end
         end
         JOB_INIT: cur = init_strobe(step_ff[3:0]);
         default: cur.last = 1'b1;
      endcase
   end

   // Load a job when idle, advance on each emitted strobe, drop on the last
   always_comb begin
      active_in    = active_ff;
      step_in      = step_ff;
      out_valid_in = out_valid_ff;
      if (out_pop) out_valid_in = 1'b0;
      if (job_pop) begin
         active_in = 1'b1;
         step_in   = '0;
      end else if (emit) begin
         out_valid_in = 1'b1;
         step_in      = step_ff + 1'b1;
         if (cur.last) active_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture job and strobe payload
   always_ff @(posedge clock) begin
      if (job_pop) job_ff <= job;
      if (emit) out_strobe_ff <= cur;
   end

endmodule

[rtl/core/char_lcd_4bit_sequencer_top.sv]
// Top level of the 4-bit character display sequencer: configuration
// registers, classifier, job queue and strobe sequencer. Depends on lcd4_pkg.
//
// Usage:
//   Requests enter through a queue-style port: a request is taken at a
//   clock edge with req_push high and req_full low. Results leave through
//   a queue-style port: while rsp_empty is low the oldest strobe
//   descriptor is on the rsp_ ports and it is taken with rsp_pop.
//   Requests with function codes 6 and 7 are taken and produce nothing.
//   csr_write_en with csr_index 0 writes line_length, 1 second_row_base.
// Flow:
//   A taken request goes into the job queue; the sequencer loads it when idle
//   and emits one strobe per cycle while the output register has room, so a
//   request gives k strobes (2 to 36), and the next one is loaded only after
//   its last strobe. A two-entry job queue lets requests queue up behind it.
// Reset and stall:
//   Synchronous reset empties both queues and restores line_length 16 and
//   second_row_base 0x40; req_full is high while reset is held. When the
//   receiver stops popping, the single output register holds its strobe,
//   the sequencer waits, then the job queue fills and req_full rises.
module char_lcd_4bit_sequencer_top
   import lcd4_pkg::*;
#(
   parameter int JOB_DEPTH = JOBQ_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic [2:0]            req_func,
   input  logic [7:0]            req_byte_value,
   input  logic [3:0]            req_column,
   input  logic                  req_row,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic                  rsp_register_select,
   output logic [3:0]            rsp_nibble,
   output logic [15:0]           rsp_wait_before_us,
   output logic [12:0]           rsp_settle_us,
   output logic                  rsp_last,
   input  logic                  csr_write_en,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   logic [4:0] line_length_ff;
   logic [6:0] second_row_base_ff;
   logic       front_valid;
   job_type    front_job;
   logic       q_full, q_empty, q_pop;
   job_type    q_job;
   logic       out_valid;
   strobe_type out_strobe;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         line_length_ff     <= LINE_LENGTH_RST;
         second_row_base_ff <= SECOND_ROW_BASE_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_LINE_LENGTH:     line_length_ff     <= csr_write_data[4:0];
            CSR_SECOND_ROW_BASE: second_row_base_ff <= csr_write_data[6:0];
            default: ;
         endcase
      end
   end

   assign req_full = q_full || reset;

   lcd4_front u_front (
      .func            (req_func),
      .byte_value      (req_byte_value),
      .column          (req_column),
      .row             (req_row),
      .second_row_base (second_row_base_ff),
      .job_valid       (front_valid),
      .job             (front_job)
   );

   lcd4_jobq #(.DEPTH(JOB_DEPTH)) u_jobq (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (req_push && front_valid && !reset),
      .wr_job (front_job),
      .rd_en  (q_pop),
      .rd_job (q_job),
      .full   (q_full),
      .empty  (q_empty)
   );

   lcd4_back u_back (
      .clock           (clock),
      .reset           (reset),
      .job_avail       (!q_empty),
      .job             (q_job),
      .job_pop         (q_pop),
      .line_length     (line_length_ff),
      .second_row_base (second_row_base_ff),
      .out_valid       (out_valid),
      .out_strobe      (out_strobe),
      .out_pop         (rsp_pop && out_valid)
   );

   assign rsp_empty           = !out_valid;
   assign rsp_register_select = out_strobe.register_select;
   assign rsp_nibble          = out_strobe.nibble;
   assign rsp_wait_before_us  = out_strobe.wait_before_us;
   assign rsp_settle_us       = out_strobe.settle_us;
   assign rsp_last            = out_strobe.last;

endmodule

[rtl/core/lcd4_checker.sv]
// Port-level checks on the display sequencer's result channel, bound to
// the top level. Depends on lcd4_pkg.
module lcd4_checker
   import lcd4_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic        rsp_register_select,
   input logic [3:0]  rsp_nibble,
   input logic [15:0] rsp_wait_before_us,
   input logic [12:0] rsp_settle_us,
   input logic        rsp_last
);

   // Reset leaves no transaction waiting
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result waiting after reset");

   // A waiting transaction holds until popped
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_nibble)
         && $stable(rsp_settle_us) && $stable(rsp_last)))
      else $error("waiting result changed");

   // Power-up wait only ahead of the first wake nibble
   a_wait_first: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_wait_before_us != 16'd0) |->
         (rsp_nibble == 4'h3 && !rsp_register_select && !rsp_last
          && rsp_settle_us == SETTLE_WAKE))
      else $error("power-up wait on wrong strobe");

   // Data strobes use base timing
   a_data_timing: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_register_select) |->
         (rsp_settle_us == SETTLE_BASE && rsp_wait_before_us == 16'd0))
      else $error("data strobe with long timing");

   // Settle time stays in range
   a_settle_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_settle_us >= SETTLE_BASE && rsp_settle_us <= SETTLE_WAKE))
      else $error("settle time out of range");

endmodule

bind char_lcd_4bit_sequencer_top lcd4_checker u_lcd4_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_empty           (rsp_empty),
   .rsp_pop             (rsp_pop),
   .rsp_register_select (rsp_register_select),
   .rsp_nibble          (rsp_nibble),
   .rsp_wait_before_us  (rsp_wait_before_us),
   .rsp_settle_us       (rsp_settle_us),
   .rsp_last            (rsp_last)
);

[tb/lcd4_tb_pkg.sv]
`timescale 1ns / 1ps
// Strobe predictor and scoreboard for the 4-bit character display sequencer.
// Depends on lcd4_pkg for the function codes, register indexes and strobe_type.
package lcd4_tb_pkg;
   import lcd4_pkg::*;

   // Function codes the block takes but ignores
   localparam logic [2:0] FUNC_SPARE_6 = 3'd6;
   localparam logic [2:0] FUNC_SPARE_7 = 3'd7;

   // Display opcodes and characters used by the composite requests
   localparam logic [7:0] OP_SET_DDRAM   = 8'h80;
   localparam logic [7:0] OP_FUNC_SET    = 8'h28;
   localparam logic [7:0] OP_DISPLAY_OFF = 8'h08;
   localparam logic [7:0] OP_ENTRY_MODE  = 8'h06;
   localparam logic [7:0] OP_DISPLAY_ON  = 8'h0C;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [3:0] NIB_WAKE       = 4'h3;
   localparam logic [3:0] NIB_FOUR_BIT   = 4'h2;

   // Timing in microseconds
   localparam int US_SETTLE     = 40;
   localparam int US_LONG       = 2000;
   localparam int US_WAKE_EXTRA = 5000;
   localparam int US_SYNC_EXTRA = 150;
   localparam int US_POWER_WAIT = 50000;

   localparam int COLS_MAX   = 16;
   localparam int SHOW_LIMIT = 200;

   class strobe_ledger;
      logic [4:0] line_length;
      logic [6:0] row_base;
      strobe_type strobes_due[$];
      strobe_type burst[$];
      int errors;
      int strobes_seen;
      int requests;
      int func_seen[8];

      function new();
         line_length  = 5'd16;
         row_base     = 7'h40;
         errors       = 0;
         strobes_seen = 0;
         requests     = 0;
         foreach (func_seen[i]) func_seen[i] = 0;
      endfunction

      function void set_reg(logic idx, logic [6:0] value);
         if (idx == CSR_LINE_LENGTH) line_length = value[4:0];
         else row_base = value;
      endfunction

      function int pending();
         return strobes_due.size();
      endfunction

      function void add_strobe(logic rs, logic [3:0] nib, int wait_us, int settle);
         strobe_type s;
         s.register_select = rs;
         s.nibble          = nib;
         s.wait_before_us  = 16'(wait_us);
         s.settle_us       = 13'(settle);
         s.last            = 1'b0;
         burst.push_back(s);
      endfunction

      // High nibble first; any extra settle goes on the low nibble
      function void add_byte(logic rs, logic [7:0] b, int extra);
         add_strobe(rs, b[7:4], 0, US_SETTLE);
         add_strobe(rs, b[3:0], 0, US_SETTLE + extra);
      endfunction

      function void add_command(logic [7:0] b);
         add_byte(1'b0, b, (b == OP_CLEAR || b == OP_HOME) ? US_LONG : 0);
      endfunction

      // Address wraps at 128 before the set-address bit goes on
      function void add_goto(logic [3:0] col, logic row);
         logic [6:0] addr;
         addr = (row ? row_base : 7'd0) + 7'(col);
         add_command(OP_SET_DDRAM | {1'b0, addr});
      endfunction

      // Work out the strobes of one accepted request and queue them
      function void note_request(logic [2:0] func, logic [7:0] b, logic [3:0] col,
                                 logic row);
         strobe_type s;
         int n;
         burst.delete();
         requests++;
         func_seen[func]++;
         case (func)
            FUNC_COMMAND: add_command(b);
            FUNC_DATA:    add_byte(1'b1, b, 0);
            FUNC_GOTO:    add_goto(col, row);
            FUNC_HOME:    add_byte(1'b0, OP_HOME, 2 * US_LONG);
            FUNC_CLRLINE: begin
               n = (line_length > COLS_MAX) ? COLS_MAX : int'(line_length);
               add_goto(4'd0, row);
               repeat (n) add_byte(1'b1, CHAR_SPACE, 0);
               add_goto(4'd0, row);
            end
            FUNC_INIT: begin
               add_strobe(1'b0, NIB_WAKE, US_POWER_WAIT, US_SETTLE + US_WAKE_EXTRA);
               add_strobe(1'b0, NIB_WAKE, 0, US_SETTLE + US_SYNC_EXTRA);
               add_strobe(1'b0, NIB_WAKE, 0, US_SETTLE + US_SYNC_EXTRA);
               add_strobe(1'b0, NIB_FOUR_BIT, 0, US_SETTLE + US_SYNC_EXTRA);
               add_command(OP_FUNC_SET);
               add_command(OP_DISPLAY_OFF);
               add_command(OP_CLEAR);
               add_command(OP_ENTRY_MODE);
               add_command(OP_DISPLAY_ON);
            end
            default: ;
         endcase
         // Mark the final strobe of the request
         foreach (burst[i]) begin
            s = burst[i];
            s.last = (i == burst.size() - 1);
            strobes_due.push_back(s);
         end
      endfunction

      function void compare(string what, logic [15:0] want, logic [15:0] got);
         if (want !== got) begin
            errors++;
            if (errors <= SHOW_LIMIT)
               $display("%0t: strobe %0d %s expected 0x%0h actual 0x%0h",
                        $time, strobes_seen, what, want, got);
            if (errors == SHOW_LIMIT)
               $display("%0t: further mismatches not shown", $time);
         end
      endfunction

      // Check one popped strobe against the oldest expectation
      function void check_strobe(strobe_type got);
         strobe_type want;
         strobes_seen++;
         if (strobes_due.size() == 0) begin
            errors++;
            if (errors <= SHOW_LIMIT)
               $display("%0t: strobe %0d expected none actual rs %0b nib 0x%0h last %0b",
                        $time, strobes_seen, got.register_select, got.nibble, got.last);
            return;
         end
         want = strobes_due.pop_front();
         compare("register_select", 16'(want.register_select), 16'(got.register_select));
         compare("nibble", 16'(want.nibble), 16'(got.nibble));
         compare("wait_before_us", want.wait_before_us, got.wait_before_us);
         compare("settle_us", 16'(want.settle_us), 16'(got.settle_us));
         compare("last", 16'(want.last), 16'(got.last));
      endfunction
   endclass

endpackage

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Top of the testbench for char_lcd_4bit_sequencer_top: clock, reset, request
// driver, popping side and run control. Depends on lcd4_pkg and lcd4_tb_pkg.
module tb_top;
   import lcd4_pkg::*;
   import lcd4_tb_pkg::*;

   localparam int PHASE_REQUESTS  = 57;
   localparam int PHASES          = 5;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int DRAIN_CYCLES    = 12;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_push = 1'b0;
   logic                  req_full;
   logic [2:0]            req_func = '0;
   logic [7:0]            req_byte_value = '0;
   logic [3:0]            req_column = '0;
   logic                  req_row = 1'b0;
   logic                  rsp_empty;
   logic                  rsp_pop = 1'b0;
   logic                  rsp_register_select;
   logic [3:0]            rsp_nibble;
   logic [15:0]           rsp_wait_before_us;
   logic [12:0]           rsp_settle_us;
   logic                  rsp_last;
   logic                  csr_write_en = 1'b0;
   logic                  csr_index = 1'b0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   strobe_ledger ledger = new();
   bit bursts_on = 1'b1;
   int req_idle_pct = 0;
   int holds_asked = 0;

   char_lcd_4bit_sequencer_top dut (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_func            (req_func),
      .req_byte_value      (req_byte_value),
      .req_column          (req_column),
      .req_row             (req_row),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_register_select (rsp_register_select),
      .rsp_nibble          (rsp_nibble),
      .rsp_wait_before_us  (rsp_wait_before_us),
      .rsp_settle_us       (rsp_settle_us),
      .rsp_last            (rsp_last),
      .csr_write_en        (csr_write_en),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Offer one request and hold it until the block takes it
   task automatic send_request(input logic [2:0] func, input logic [7:0] b,
                               input logic [3:0] col, input logic row);
      if (bursts_on && req_idle_pct > 0 && $urandom_range(99) < req_idle_pct) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_push       <= 1'b1;
      req_func       <= func;
      req_byte_value <= b;
      req_column     <= col;
      req_row        <= row;
      do @(posedge clock); while (req_full);
      ledger.note_request(func, b, col, row);
   endtask

   // Random request: spare codes now and then, raw clear and home often enough
   task automatic send_random(output bit counted);
      logic [2:0] func;
      logic [7:0] b;
      func = ($urandom_range(19) == 0) ? 3'($urandom_range(FUNC_SPARE_6, FUNC_SPARE_7))
                                       : 3'($urandom_range(FUNC_INIT));
      b = 8'($urandom);
      if (func == FUNC_COMMAND && $urandom_range(7) == 0)
         b = $urandom_range(1) ? OP_CLEAR : OP_HOME;
      send_request(func, b, 4'($urandom), 1'($urandom));
      counted = (func <= FUNC_INIT);
   endtask

   // Drop push and wait until every expected strobe is out and the block is quiet
   task automatic drain();
      req_push <= 1'b0;
      while (ledger.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [6:0] value);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      ledger.set_reg(idx, value);
      @(posedge clock);
   endtask

   // Pop side: check each transaction, stall in bursts, serve long hold-offs
   initial begin : rsp_side
      strobe_type got;
      int stall_left;
      int hold_left;
      int mode_left;
      int stall_pct;
      int holds_served;
      stall_left   = 0;
      hold_left    = 0;
      mode_left    = 0;
      stall_pct    = 0;
      holds_served = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty) begin
            got.register_select = rsp_register_select;
            got.nibble          = rsp_nibble;
            got.wait_before_us  = rsp_wait_before_us;
            got.settle_us       = rsp_settle_us;
            got.last            = rsp_last;
            ledger.check_strobe(got);
         end
         if (holds_served < holds_asked) begin
            holds_served++;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (mode_left == 0) begin
            mode_left = 64;
            case ($urandom_range(2))
               0: stall_pct = 0;
               1: stall_pct = 10;
               default: stall_pct = 40;
            endcase
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_pop <= 1'b0;
         end else if (bursts_on && $urandom_range(99) < stall_pct) begin
            stall_left = $urandom_range(1, 18) - 1;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      bit counted;
      int sent;
      logic [4:0] len_plan [PHASES];
      logic [6:0] base_plan [PHASES];
      len_plan  = '{5'd16, 5'd0, 5'd31, 5'd1, 5'($urandom)};
      base_plan = '{7'h40, 7'h7F, 7'h00, 7'($urandom), 7'($urandom)};

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: every function, field extremes, raw clear and home, spare codes
      send_request(FUNC_INIT, 8'($urandom), 4'($urandom), 1'($urandom));
      send_request(FUNC_COMMAND, OP_CLEAR, 4'($urandom), 1'($urandom));
      send_request(FUNC_COMMAND, OP_HOME, 4'($urandom), 1'($urandom));
      send_request(FUNC_COMMAND, 8'h00, 4'($urandom), 1'($urandom));
      send_request(FUNC_COMMAND, 8'hFF, 4'($urandom), 1'($urandom));
      send_request(FUNC_DATA, 8'h00, 4'($urandom), 1'($urandom));
      send_request(FUNC_DATA, 8'hFF, 4'($urandom), 1'($urandom));
      send_request(FUNC_DATA, 8'hA5, 4'($urandom), 1'($urandom));
      send_request(FUNC_GOTO, 8'($urandom), 4'd0, 1'b0);
      send_request(FUNC_GOTO, 8'($urandom), 4'd15, 1'b1);
      send_request(FUNC_HOME, 8'($urandom), 4'($urandom), 1'($urandom));
      send_request(FUNC_CLRLINE, 8'($urandom), 4'($urandom), 1'b0);
      send_request(FUNC_CLRLINE, 8'($urandom), 4'($urandom), 1'b1);
      send_request(FUNC_SPARE_6, 8'($urandom), 4'($urandom), 1'($urandom));
      send_request(FUNC_SPARE_7, 8'($urandom), 4'($urandom), 1'($urandom));

      // Empty clear line sends only the two address commands
      drain();
      write_reg(CSR_LINE_LENGTH, 7'd0);
      send_request(FUNC_CLRLINE, 8'($urandom), 4'($urandom), 1'b1);
      // Oversized line length saturates at sixteen columns
      drain();
      write_reg(CSR_LINE_LENGTH, 7'h1F);
      send_request(FUNC_CLRLINE, 8'($urandom), 4'($urandom), 1'b0);
      // Top row base: the address wraps past 127
      drain();
      write_reg(CSR_LINE_LENGTH, 7'd1);
      write_reg(CSR_SECOND_ROW_BASE, 7'h7F);
      send_request(FUNC_CLRLINE, 8'($urandom), 4'($urandom), 1'b1);
      send_request(FUNC_GOTO, 8'($urandom), 4'd15, 1'b1);
      send_request(FUNC_GOTO, 8'($urandom), 4'd1, 1'b1);
      drain();
      write_reg(CSR_LINE_LENGTH, 7'd17);
      write_reg(CSR_SECOND_ROW_BASE, 7'h00);
      send_request(FUNC_GOTO, 8'($urandom), 4'd15, 1'b1);
      send_request(FUNC_CLRLINE, 8'($urandom), 4'($urandom), 1'b1);

      // Random phases, each under its own register setting
      for (int phase = 0; phase < PHASES; phase++) begin
         drain();
         write_reg(CSR_LINE_LENGTH, {2'($urandom), len_plan[phase]});
         write_reg(CSR_SECOND_ROW_BASE, base_plan[phase]);
         // Hold the pop side off so the block fills and raises full
         if (phase == 1) holds_asked++;
         // No idling on either side in the last phase
         if (phase == PHASES - 1) begin
            bursts_on    = 1'b0;
            req_idle_pct = 0;
         end
         sent = 0;
         while (sent < PHASE_REQUESTS) begin
            if (bursts_on && $urandom_range(15) == 0)
               case ($urandom_range(2))
                  0: req_idle_pct = 0;
                  1: req_idle_pct = 15;
                  default: req_idle_pct = 50;
               endcase
            send_random(counted);
            if (counted) sent++;
         end
      end

      drain();
      $display("Covered %0d requests (%0d init, %0d clear line, %0d goto, %0d spare codes),",
               ledger.requests, ledger.func_seen[FUNC_INIT], ledger.func_seen[FUNC_CLRLINE],
               ledger.func_seen[FUNC_GOTO],
               ledger.func_seen[FUNC_SPARE_6] + ledger.func_seen[FUNC_SPARE_7]);
      $display(
         "%0d strobes checked over line lengths 0 to 31, row bases 0 to 127, one long hold-off",
         ledger.strobes_seen);
      if (ledger.errors == 0 && ledger.pending() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Stop a hung run
   initial begin : watchdog
      #20_000_000;
      $display("%0t: timeout with %0d strobes outstanding", $time, ledger.pending());
      $display("DONE: errors detected");
      $finish;
   end

endmodule

[filelist.f]
rtl/core/lcd4_pkg.sv
rtl/core/lcd4_front.sv
rtl/core/lcd4_jobq.sv
rtl/core/lcd4_back.sv
rtl/core/char_lcd_4bit_sequencer_top.sv
rtl/core/lcd4_checker.sv
tb/lcd4_tb_pkg.sv
tb/tb_top.sv
